### design/hcbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

    // chunk size register width
    localparam int SIZE_WIDTH = 32;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF_HEX = 8'h66;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;

    // bytes skipped after chunk data
    localparam logic [1:0] TRAILER_BYTES = 2'd2;

    // classified body byte handed from front to back
    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_last;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_blank;
        logic       is_cr;
        logic       is_lf;
    } hcbd_item_t;

endpackage

`default_nettype wire

### design/hcbd_if.sv
`timescale 1ns / 1ps
`default_nettype none

// raw body byte channel
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       body_last;

    modport source (output valid, output body_byte, output body_last, input ready);
    modport sink (input valid, input body_byte, input body_last, output ready);
endinterface

// decoded result channel
interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic       data_valid;
    logic [7:0] payload_byte;
    logic       body_done;
    logic       clean_end;

    modport source (output valid, output data_valid, output payload_byte,
                    output body_done, output clean_end, input ready);
    modport sink (input valid, input data_valid, input payload_byte,
                  input body_done, input clean_end, output ready);
endinterface

`default_nettype wire

### design/hcbd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_front
    import hcbd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    hcbd_in_if.sink     body_in,
    output hcbd_item_t  item,
    output logic        item_valid,
    input  wire logic   item_pop
);

    hcbd_item_t               class_item;
    hcbd_item_t               queue_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic                     push;
    logic                     pop;

    // classify the incoming byte
    always_comb
    begin
        class_item           = '0;
        class_item.body_byte = body_in.body_byte;
        class_item.body_last = body_in.body_last;
        class_item.is_blank  = (body_in.body_byte == CHAR_SPACE) ||
                               (body_in.body_byte == CHAR_TAB);
        class_item.is_cr     = (body_in.body_byte == CHAR_CR);
        class_item.is_lf     = (body_in.body_byte == CHAR_LF);
        if (body_in.body_byte >= CHAR_0 && body_in.body_byte <= CHAR_9)
        begin
            class_item.is_hex  = 1'b1;
            class_item.hex_val = 4'(body_in.body_byte - CHAR_0);
        end
        else if (body_in.body_byte >= CHAR_LA && body_in.body_byte <= CHAR_LF_HEX)
        begin
            class_item.is_hex  = 1'b1;
            class_item.hex_val = 4'(body_in.body_byte - CHAR_LA + 8'd10);
        end
        else if (body_in.body_byte >= CHAR_UA && body_in.body_byte <= CHAR_UF)
        begin
            class_item.is_hex  = 1'b1;
            class_item.hex_val = 4'(body_in.body_byte - CHAR_UA + 8'd10);
        end
    end

    // queue handshake
    assign body_in.ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push          = body_in.valid && body_in.ready;
    assign item_valid    = (count_reg != '0);
    assign pop           = item_pop && item_valid;
    assign item          = queue_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= class_item;
        end
    end

endmodule

`default_nettype wire

### design/hcbd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_back
    import hcbd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire hcbd_item_t  item,
    input  wire logic        item_valid,
    output logic             item_pop,
    hcbd_out_if.source       body_out
);

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_DIGITS = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_SKIP   = 4'b1000
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [SIZE_WIDTH-1:0]   remaining_reg, remaining_next;
    logic [SIZE_WIDTH-1:0]   remaining_dec;
    logic                    digits_closed_reg, digits_closed_next;
    logic                    cr_seen_reg, cr_seen_next;
    logic [1:0]              skip_reg, skip_next;
    logic                    finished_reg, finished_next;
    logic                    step;
    logic                    emit;
    logic                    valid_now;
    logic                    done_now;
    logic                    size_saturated;

    logic                    out_valid_reg, out_valid_next;
    logic                    data_valid_reg;
    logic [7:0]              payload_reg;
    logic                    body_done_reg;
    logic                    clean_end_reg;

    // take a queued item when the result register is free or draining
    assign step     = item_valid && (!out_valid_reg || body_out.ready);
    assign item_pop = step;

    assign remaining_dec  = remaining_reg - 1'b1;
    assign size_saturated = |remaining_reg[SIZE_WIDTH-1 -: 4];

    // chunk parser next state
    always_comb
    begin
        phase_next         = phase_reg;
        remaining_next     = remaining_reg;
        digits_closed_next = digits_closed_reg;
        cr_seen_next       = cr_seen_reg;
        skip_next          = skip_reg;
        finished_next      = finished_reg;
        valid_now          = 1'b0;
        done_now           = 1'b0;

        if (!finished_reg)
        begin
            unique case (phase_reg)
                PH_DATA:
                begin
                    valid_now      = 1'b1;
                    remaining_next = remaining_dec;
                    if (remaining_dec == '0)
                    begin
                        phase_next = PH_SKIP;
                        skip_next  = TRAILER_BYTES;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - 1'b1;
                    if (skip_reg == 2'd1)
                    begin
                        phase_next         = PH_START;
                        remaining_next     = '0;
                        digits_closed_next = 1'b0;
                        cr_seen_next       = 1'b0;
                        skip_next          = '0;
                    end
                end
                PH_START, PH_DIGITS:
                begin
                    if (cr_seen_reg && item.is_lf)
                    begin
                        // end of size line
                        if (remaining_reg == '0)
                        begin
                            finished_next = 1'b1;
                            done_now      = 1'b1;
                        end
                        else
                        begin
                            phase_next         = PH_DATA;
                            digits_closed_next = 1'b0;
                            cr_seen_next       = 1'b0;
                        end
                    end
                    else if (cr_seen_reg)
                    begin
                        // lone cr is a non-hex line byte, so any later size digit is ignored
                        digits_closed_next = 1'b1;
                        cr_seen_next       = item.is_cr;
                    end
                    else if (item.is_cr)
                    begin
                        cr_seen_next = 1'b1;
                    end
                    else if (!digits_closed_reg)
                    begin
                        if (phase_reg == PH_START && item.is_blank)
                        begin
                            phase_next = PH_START;
                        end
                        else if (!item.is_hex)
                        begin
                            digits_closed_next = 1'b1;
                        end
                        else
                        begin
                            phase_next     = PH_DIGITS;
                            remaining_next = size_saturated ? '1 :
                                             {remaining_reg[SIZE_WIDTH-5:0], item.hex_val};
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
        end

        // end of body returns to the reset state
        if (item.body_last)
        begin
            phase_next         = PH_START;
            remaining_next     = '0;
            digits_closed_next = 1'b0;
            cr_seen_next       = 1'b0;
            skip_next          = '0;
            finished_next      = 1'b0;
        end
    end

    assign emit = !finished_reg && (valid_now || done_now || item.body_last);

    // result register valid
    always_comb
    begin
        if (step)
        begin
            out_valid_next = emit;
        end
        else
        begin
            out_valid_next = out_valid_reg && !body_out.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_START;
            remaining_reg     <= '0;
            digits_closed_reg <= 1'b0;
            cr_seen_reg       <= 1'b0;
            skip_reg          <= '0;
            finished_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                phase_reg         <= phase_next;
                remaining_reg     <= remaining_next;
                digits_closed_reg <= digits_closed_next;
                cr_seen_reg       <= cr_seen_next;
                skip_reg          <= skip_next;
                finished_reg      <= finished_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            data_valid_reg <= valid_now;
            payload_reg    <= valid_now ? item.body_byte : 8'h00;
            body_done_reg  <= done_now || item.body_last;
            clean_end_reg  <= done_now;
        end
    end

    assign body_out.valid        = out_valid_reg;
    assign body_out.data_valid   = data_valid_reg;
    assign body_out.payload_byte = payload_reg;
    assign body_out.body_done    = body_done_reg;
    assign body_out.clean_end    = clean_end_reg;

endmodule

`default_nettype wire

### design/http_chunked_body_decoder_top.sv
// channel    dir  handshake      payload
// body_in    in   valid / ready  body_byte[7:0], body_last
// body_out   out  valid / ready  data_valid, payload_byte[7:0], body_done, clean_end
//
// one body byte per cycle when body_out is not stalled
// a byte is queued at its accepting edge and its result is then registered in the result register
// a two-entry queue between classifier and parser absorbs short output stalls
// bytes that give no result leave no output item
// rst_n clears the queue, the parser state and the result register
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_body_decoder_top
    import hcbd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    hcbd_in_if.sink     body_in,
    hcbd_out_if.source  body_out
);

    hcbd_item_t  item;
    logic        item_valid;
    logic        item_pop;

    // byte classifier and queue
    hcbd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .body_in    (body_in),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    // chunk parser and result register
    hcbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .body_out   (body_out)
    );

endmodule

`default_nettype wire
